// ===== rtl/core/mi3_pkg.sv =====
// Shared constants and the cofactor operand table for the 3x3 matrix inverse.
package mi3_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_ELEM       = 9;

  // Operand indices (row-major) of each adjugate entry: x*y - u*v.
  localparam int COF_IDX [NUM_ELEM][4] = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

endpackage

// ===== rtl/core/mi3_if.sv =====
// Valid/ready channel interfaces for the matrix input and the inverse result.
interface mi3_in_if import mi3_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

interface mi3_out_if import mi3_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [W-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  logic singular;
  logic saturated;

  modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
                  inv22, singular, saturated, input ready);
  modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
                  inv22, singular, saturated, output ready);
endinterface

// ===== rtl/core/mi3_cof_lane.sv =====
// One cofactor lane: two registered products, then their registered difference.
module mi3_cof_lane import mi3_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   x,
  input  logic signed [W-1:0]   y,
  input  logic signed [W-1:0]   u,
  input  logic signed [W-1:0]   v,
  output logic signed [2*W:0]   cof
);
  logic signed [2*W-1:0] p_nxt, q_nxt, p_r, q_r;
  logic signed [2*W:0]   cof_r;

  assign p_nxt = x * y;
  assign q_nxt = u * v;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p_nxt;
      q_r   <= q_nxt;
      cof_r <= (2*W+1)'(p_r) - (2*W+1)'(q_r);
    end
  end

  assign cof = cof_r;
endmodule

// ===== rtl/core/mi3_det.sv =====
// Merging stage: determinant from row 0 and its cofactors, with cofactors delayed to match.
module mi3_det import mi3_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] row0 [3],
  input  logic signed [2*W:0] cof_in [NUM_ELEM],
  output logic signed [3*W:0] det,
  output logic signed [2*W:0] cof_out [NUM_ELEM]
);
  localparam int CW = 2*W + 1;
  localparam int DW = 3*W + 1;

  // Row 0 multiplies adjugate column 0, i.e. cofactors 0, 3 and 6.
  logic signed [CW-1:0]  cof_sel [3];
  logic signed [2*W:0]   lo_nxt [3];
  logic signed [2*W:0]   hi_nxt [3];
  logic signed [2*W:0]   lo_r [3];
  logic signed [2*W:0]   hi_r [3];
  logic signed [DW-1:0]  term_r [3];
  logic signed [DW-1:0]  det_r;
  logic signed [CW-1:0]  cd0_r [NUM_ELEM];
  logic signed [CW-1:0]  cd1_r [NUM_ELEM];
  logic signed [CW-1:0]  cd2_r [NUM_ELEM];

  assign cof_sel[0] = cof_in[0];
  assign cof_sel[1] = cof_in[3];
  assign cof_sel[2] = cof_in[6];

  // Split each cofactor into an unsigned low word and a signed high part.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lo_nxt[j] = row0[j] * $signed({1'b0, cof_sel[j][W-1:0]});
      hi_nxt[j] = row0[j] * $signed(cof_sel[j][CW-1:W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        lo_r[j]   <= lo_nxt[j];
        hi_r[j]   <= hi_nxt[j];
        term_r[j] <= (DW'(hi_r[j]) <<< W) + DW'(lo_r[j]);
      end
      det_r <= term_r[0] + term_r[1] + term_r[2];
      cd0_r <= cof_in;
      cd1_r <= cd0_r;
      cd2_r <= cd1_r;
    end
  end

  assign det     = det_r;
  assign cof_out = cd2_r;
endmodule

// ===== rtl/core/mi3_div_lane.sv =====
// One divider lane: rounded quotient of cofactor by determinant, one bit per stage, saturated.
module mi3_div_lane import mi3_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [2*W:0] cof,
  input  logic signed [3*W:0] det,
  output logic [W-1:0]        quo,
  output logic                sat
);
  localparam int CW   = 2*W + 1;
  localparam int CMW  = 2*W;
  localparam int DW   = 3*W + 1;
  localparam int DMW  = 3*W;
  localparam int NWA  = CMW + 2*F + 1;
  localparam int NW   = ((NWA > DMW) ? NWA : DMW) + 1;
  localparam int RW   = (NW > DMW + 1 + W) ? NW : DMW + 1 + W;

  logic [CW-1:0]  cabs;
  logic [DW-1:0]  dabs;
  logic [RW-1:0]  n_full;
  logic [DMW:0]   d_full;
  logic           over_nxt;
  logic           neg_nxt;

  logic [RW-1:0]  rem_r  [W];
  logic [DMW:0]   d_r    [W];
  logic [W-1:0]   q_r    [W+1];
  logic           neg_r  [W+1];
  logic           over_r [W+1];

  logic [W-1:0]   lim;
  logic           clip;
  logic [W-1:0]   mag;
  logic [W-1:0]   quo_r;
  logic           sat_r;

  // Numerator carries half the divisor so that the floor rounds to nearest.
  always_comb begin
    cabs     = cof[CW-1] ? CW'(-cof) : CW'(cof);
    dabs     = det[DW-1] ? DW'(-det) : DW'(det);
    n_full   = (RW'(cabs[CMW-1:0]) << (2*F + 1)) + RW'(dabs[DMW-1:0]);
    d_full   = {dabs[DMW-1:0], 1'b0};
    over_nxt = n_full >= (RW'(d_full) << W);
    neg_nxt  = cof[CW-1] ^ det[DW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= n_full;
      d_r[0]    <= d_full;
      q_r[0]    <= '0;
      neg_r[0]  <= neg_nxt;
      over_r[0] <= over_nxt;
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [RW-1:0] sub;
    logic          ge;

    assign sub = RW'(d_r[i]) << (W - 1 - i);
    assign ge  = rem_r[i] >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1]    <= {q_r[i][W-2:0], ge};
        neg_r[i+1]  <= neg_r[i];
        over_r[i+1] <= over_r[i];
      end
    end

    if (i < W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= ge ? rem_r[i] - sub : rem_r[i];
          d_r[i+1]   <= d_r[i];
        end
      end
    end
  end

  // A negative result may reach one step further than a positive one.
  always_comb begin
    lim  = neg_r[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    clip = over_r[W] || (q_r[W] > lim);
    mag  = clip ? lim : q_r[W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= neg_r[W] ? W'(-mag) : mag;
      sat_r <= clip;
    end
  end

  assign quo = quo_r;
  assign sat = sat_r;
endmodule

// ===== rtl/core/matrix_inverse_3x3.sv =====
// Top level of the pipelined 3x3 matrix inverse by adjugate and determinant.
//
// Usage: present one matrix per transaction on in_if (nine signed fixed-point
// elements, FRAC_BITS fraction bits). Each matrix yields exactly one transaction
// on out_if with the nine inverse elements, rounded to nearest and clipped to
// DATA_WIDTH bits. singular is set, with all elements zero, when the
// determinant is zero; otherwise saturated is set when any element was clipped.
// The pipeline runs through one input register, the registered cofactor
// products and their difference, the determinant merging registers, and
// the divider lanes, which retire one quotient bit per stage. Throughput is
// one matrix per cycle while out_if is not stalled.
// The whole pipeline advances together: when out_if holds a result that the
// receiver does not take, every stage holds and in_if.ready drops; while
// the output register is empty or being drained, a new matrix is taken
// every cycle. Synchronous active-low reset clears only the valid flags.
module matrix_inverse_3x3 import mi3_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mi3_in_if.sink     in_if,
  mi3_out_if.source  out_if
);
  localparam int W   = DATA_WIDTH;
  localparam int LAT = W + 8;
  localparam int SL  = W + 2;

  logic                 adv;
  logic [LAT-1:0]       v_r;
  logic signed [W-1:0]  a_r     [NUM_ELEM];
  logic signed [W-1:0]  row0_d1_r [3];
  logic signed [W-1:0]  row0_d2_r [3];
  logic signed [2*W:0]  cof     [NUM_ELEM];
  logic signed [2*W:0]  cof_d   [NUM_ELEM];
  logic signed [3*W:0]  det;
  logic [SL-1:0]        sing_r;
  logic [W-1:0]         quo     [NUM_ELEM];
  logic [NUM_ELEM-1:0]  sat;
  logic                 sing;

  assign adv         = out_if.ready || !v_r[LAT-1];
  assign in_if.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], in_if.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r[0] <= in_if.a00;
      a_r[1] <= in_if.a01;
      a_r[2] <= in_if.a02;
      a_r[3] <= in_if.a10;
      a_r[4] <= in_if.a11;
      a_r[5] <= in_if.a12;
      a_r[6] <= in_if.a20;
      a_r[7] <= in_if.a21;
      a_r[8] <= in_if.a22;
      row0_d1_r <= a_r[0:2];
      row0_d2_r <= row0_d1_r;
      sing_r    <= {sing_r[SL-2:0], (det == '0)};
    end
  end

  for (genvar g = 0; g < NUM_ELEM; g++) begin : g_cof
    mi3_cof_lane #(.W(W)) u_cof (
      .clk (clk),
      .en  (adv),
      .x   (a_r[COF_IDX[g][0]]),
      .y   (a_r[COF_IDX[g][1]]),
      .u   (a_r[COF_IDX[g][2]]),
      .v   (a_r[COF_IDX[g][3]]),
      .cof (cof[g])
    );
  end

  mi3_det #(.W(W)) u_det (
    .clk     (clk),
    .en      (adv),
    .row0    (row0_d2_r),
    .cof_in  (cof),
    .det     (det),
    .cof_out (cof_d)
  );

  for (genvar g = 0; g < NUM_ELEM; g++) begin : g_div
    mi3_div_lane #(.W(W), .F(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (adv),
      .cof (cof_d[g]),
      .det (det),
      .quo (quo[g]),
      .sat (sat[g])
    );
  end

  assign sing = sing_r[SL-1];

  assign out_if.valid     = v_r[LAT-1];
  assign out_if.inv00     = sing ? '0 : quo[0];
  assign out_if.inv01     = sing ? '0 : quo[1];
  assign out_if.inv02     = sing ? '0 : quo[2];
  assign out_if.inv10     = sing ? '0 : quo[3];
  assign out_if.inv11     = sing ? '0 : quo[4];
  assign out_if.inv12     = sing ? '0 : quo[5];
  assign out_if.inv20     = sing ? '0 : quo[6];
  assign out_if.inv21     = sing ? '0 : quo[7];
  assign out_if.inv22     = sing ? '0 : quo[8];
  assign out_if.singular  = sing;
  assign out_if.saturated = !sing && (|sat);

  a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.singular |-> !out_if.saturated && out_if.inv00 == '0 &&
      out_if.inv11 == '0 && out_if.inv22 == '0)
    else $error("singular result carries a nonzero value or a clip flag");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r) && $stable(sing_r))
    else $error("pipeline moved while the output was stalled");

  a_ready_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[LAT-1] |-> in_if.ready)
    else $error("input refused with an empty output register");
endmodule
